// ===== rtl/fcd_pkg.sv =====
// Force contact detector package: transaction types, control structs,
// register indexes, reset values and saturation helpers.
// No dependencies; the lane, merge, top and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_WEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT  = 3'd4;

  localparam logic        [15:0] FILTER_GAIN_RST     = 16'd58982;
  localparam logic        [19:0] LOAD_WEIGHT_RST     = 20'd4017;
  localparam logic        [22:0] FORCE_THRESHOLD_RST = 23'd3277;
  localparam logic signed [23:0] DEPTH_THRESHOLD_RST = 24'sd3277;
  localparam logic signed [23:0] SURFACE_HEIGHT_RST  = 24'sd7012;

  typedef enum logic [1:0] {
    CS_NONE    = 2'd0,
    CS_NEAR    = 2'd1,
    CS_CONTACT = 2'd2
  } contact_t;

  typedef struct packed {
    logic signed [23:0] force_x;
    logic signed [23:0] force_y;
    logic signed [23:0] force_z;
    logic signed [15:0] rot_zx;
    logic signed [15:0] rot_zy;
    logic signed [15:0] rot_zz;
    logic signed [23:0] tool_height;
  } in_item_t;

  typedef struct packed {
    logic               bias_ready;
    logic signed [23:0] normal_force;
    logic signed [23:0] force_average;
    contact_t           contact_state;
    logic signed [23:0] filtered_x;
    logic signed [23:0] filtered_y;
    logic signed [23:0] filtered_z;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CAL,
    ST_CDIV_A,
    ST_CDIV_B,
    ST_CDIV_C,
    ST_COMP,
    ST_FILT,
    ST_PROJ,
    ST_SUM,
    ST_WIN,
    ST_ADIV_A,
    ST_ADIV_B,
    ST_ADIV_C,
    ST_OUT
  } state_t;

  // Strobes shared by the three axis lanes
  typedef struct packed {
    logic capture;
    logic load_term;
    logic cal_acc;
    logic bias_load;
    logic comp;
    logic filt;
    logic proj;
  } lane_ctrl_t;

  // Strobes for the merging stage
  typedef struct packed {
    logic sum;
    logic win;
    logic avg_load;
  } merge_ctrl_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -48'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/force_contact_detector.sv =====
// Force contact detector top: config registers, sequencer, lanes, merge, output reg.
// Steps: capture, load term; calibration accumulate (plus bias divide on the last one);
// once calibrated, compensate, filter, project, sum, window (plus average divide when
// full); output load. New items are accepted again in the cycle after the result loads.
// Synchronous reset restores register defaults and clears calibration, filter
// and window counters; window storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module force_contact_detector
  import fcd_pkg::*;
#(
  parameter int unsigned CALIB_SAMPLES = 64,
  parameter int unsigned WINDOW_LEN    = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CAL_W = $clog2(CALIB_SAMPLES + 1);
  localparam logic [CAL_W-1:0] CAL_TOP = CAL_W'(CALIB_SAMPLES);

  state_t              state_r;
  state_t              state_nxt;
  logic                bias_done_r;
  logic                bias_done_nxt;
  logic [CAL_W-1:0]    calib_cnt_r;
  logic [CAL_W-1:0]    calib_cnt_nxt;
  logic signed [23:0]  th_r;
  logic [15:0]         gain_r;
  logic [19:0]         load_r;
  logic [22:0]         fthr_r;
  logic signed [23:0]  depth_r;
  logic signed [23:0]  surf_r;
  logic                out_valid_r;
  out_item_t           out_data_r;
  out_item_t           res;
  logic                out_load;
  lane_ctrl_t          lctrl;
  merge_ctrl_t         mctrl;
  logic                win_full;
  logic signed [23:0]  nf;
  logic signed [23:0]  avg;
  logic signed [24:0]  height_gap;
  logic                near;
  logic                heavy;

  logic signed [23:0]  raw_a  [3];
  logic signed [15:0]  row_a  [3];
  logic signed [23:0]  filt_a [3];
  logic signed [39:0]  prod_a [3];

  assign raw_a[0] = in_data.force_x;
  assign raw_a[1] = in_data.force_y;
  assign raw_a[2] = in_data.force_z;
  assign row_a[0] = in_data.rot_zx;
  assign row_a[1] = in_data.rot_zy;
  assign row_a[2] = in_data.rot_zz;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= FILTER_GAIN_RST;
      load_r  <= LOAD_WEIGHT_RST;
      fthr_r  <= FORCE_THRESHOLD_RST;
      depth_r <= DEPTH_THRESHOLD_RST;
      surf_r  <= SURFACE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILTER_GAIN:     gain_r  <= cfg_data[15:0];
        CFG_LOAD_WEIGHT:     load_r  <= cfg_data[19:0];
        CFG_FORCE_THRESHOLD: fthr_r  <= cfg_data[22:0];
        CFG_DEPTH_THRESHOLD: depth_r <= cfg_data;
        CFG_SURFACE_HEIGHT:  surf_r  <= cfg_data;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    fcd_lane #(
      .CALIB_SAMPLES (CALIB_SAMPLES)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (lctrl),
      .raw         (raw_a[k]),
      .row         (row_a[k]),
      .load_weight (load_r),
      .filter_gain (gain_r),
      .filt        (filt_a[k]),
      .prod        (prod_a[k])
    );
  end

  fcd_merge #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (mctrl),
    .prod_x        (prod_a[0]),
    .prod_y        (prod_a[1]),
    .prod_z        (prod_a[2]),
    .win_full      (win_full),
    .normal_force  (nf),
    .force_average (avg)
  );

  assign in_stall = (state_r != ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bias_done_r <= 1'b0;
      calib_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      bias_done_r <= bias_done_nxt;
      calib_cnt_r <= calib_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bias_done_nxt = bias_done_r;
    calib_cnt_nxt = calib_cnt_r;
    lctrl         = '0;
    mctrl         = '0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          lctrl.capture = 1'b1;
          state_nxt     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        lctrl.load_term = 1'b1;
        state_nxt       = bias_done_r ? ST_COMP : ST_CAL;
      end
      ST_CAL: begin
        lctrl.cal_acc = 1'b1;
        calib_cnt_nxt = calib_cnt_r + CAL_W'(1);
        state_nxt     = (calib_cnt_nxt == CAL_TOP) ? ST_CDIV_A : ST_OUT;
      end
      ST_CDIV_A: state_nxt = ST_CDIV_B;
      ST_CDIV_B: state_nxt = ST_CDIV_C;
      ST_CDIV_C: begin
        lctrl.bias_load = 1'b1;
        bias_done_nxt   = 1'b1;
        state_nxt       = ST_COMP;
      end
      ST_COMP: begin
        lctrl.comp = 1'b1;
        state_nxt  = ST_FILT;
      end
      ST_FILT: begin
        lctrl.filt = 1'b1;
        state_nxt  = ST_PROJ;
      end
      ST_PROJ: begin
        lctrl.proj = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        mctrl.sum = 1'b1;
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        mctrl.win = 1'b1;
        state_nxt = win_full ? ST_ADIV_A : ST_OUT;
      end
      ST_ADIV_A: state_nxt = ST_ADIV_B;
      ST_ADIV_B: state_nxt = ST_ADIV_C;
      ST_ADIV_C: begin
        mctrl.avg_load = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lctrl.capture) begin
      th_r <= in_data.tool_height;
    end
  end

  // Contact classification
  always_comb begin
    height_gap = 25'(th_r) - 25'(surf_r);
    near       = (height_gap < 25'(depth_r));
    heavy      = (25'(avg) >= $signed({2'b00, fthr_r}));
    res        = '0;
    if (bias_done_r) begin
      res.bias_ready    = 1'b1;
      res.normal_force  = nf;
      res.force_average = avg;
      res.filtered_x    = filt_a[0];
      res.filtered_y    = filt_a[1];
      res.filtered_z    = filt_a[2];
      if (!near) begin
        res.contact_state = CS_NONE;
      end else if (heavy) begin
        res.contact_state = CS_CONTACT;
      end else begin
        res.contact_state = CS_NEAR;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/fcd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fcd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/fcd_cdiv.sv =====
// Floor division of a signed 33-bit value by a fixed divisor, by reciprocal
// multiplication with one correction step. Two register stages, result
// combinational from the second. Magnitude after folding must stay below 2^32.
`timescale 1ns / 1ps
`default_nettype none

module fcd_cdiv #(
  parameter int unsigned DIVISOR = 16
) (
  input  wire logic               clk,
  input  wire logic signed [32:0] num,
  output logic signed [32:0]      quo
);

  localparam int unsigned LOG2D      = $clog2(DIVISOR);
  localparam int unsigned SHIFT      = 31 + LOG2D;
  localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(DIVISOR);
  localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
  localparam logic [43:0] DIV_W      = 44'(DIVISOR);
  localparam logic [33:0] ROUND_UP   = 34'(DIVISOR - 1);

  logic [33:0] mag;
  logic [31:0] u_nxt;
  logic [31:0] u_r;
  logic        neg_r;
  logic [63:0] prod_nxt;
  logic [63:0] prod_r;
  logic [31:0] u2_r;
  logic        neg2_r;
  logic [31:0] q0;
  logic [43:0] qd;
  logic [43:0] rem;
  logic [32:0] q;

  // Negative numerators: floor(n/D) = -floor((-n + D - 1)/D)
  always_comb begin
    mag   = (~{num[32], num}) + 34'd1 + ROUND_UP;
    u_nxt = num[32] ? mag[31:0] : num[31:0];
  end

  assign prod_nxt = 64'(u_r) * 64'(RECIP);

  always_ff @(posedge clk) begin
    u_r    <= u_nxt;
    neg_r  <= num[32];
    prod_r <= prod_nxt;
    u2_r   <= u_r;
    neg2_r <= neg_r;
  end

  // Estimate is at most one low; fix it with one compare
  always_comb begin
    q0  = 32'(prod_r >> SHIFT);
    qd  = 44'(q0) * DIV_W;
    rem = 44'(u2_r) - qd;
    q   = 33'(q0) + ((rem >= DIV_W) ? 33'd1 : 33'd0);
    quo = neg2_r ? (~q + 33'd1) : q;
  end

endmodule

`default_nettype wire

// ===== rtl/fcd_lane.sv =====
// One axis lane: tool load term, bias calibration, compensation, exponential
// filter and projection onto the world-z row. Uses fcd_pkg and fcd_cdiv.
`timescale 1ns / 1ps
`default_nettype none

module fcd_lane
  import fcd_pkg::*;
#(
  parameter int unsigned CALIB_SAMPLES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lane_ctrl_t         ctrl,
  input  wire logic signed [23:0] raw,
  input  wire logic signed [15:0] row,
  input  wire logic        [19:0] load_weight,
  input  wire logic        [15:0] filter_gain,
  output logic signed      [23:0] filt,
  output logic signed      [39:0] prod
);

  logic signed [23:0] raw_r;
  logic signed [15:0] row_r;
  logic signed [21:0] lt_r;
  logic signed [21:0] lt_nxt;
  logic signed [31:0] bias_sum_r;
  logic signed [31:0] bias_acc;
  logic signed [23:0] w_r;
  logic signed [23:0] w_nxt;
  logic signed [23:0] s_r;
  logic signed [23:0] s_nxt;
  logic signed [39:0] prod_r;
  logic signed [39:0] prod_nxt;
  logic signed [36:0] lprod;
  logic signed [24:0] diff;
  logic signed [41:0] fprod;
  logic signed [47:0] facc;
  logic signed [32:0] quo;

  always_comb begin
    lprod    = $signed({1'b0, load_weight}) * row_r;
    lt_nxt   = 22'((lprod + 37'sd16384) >>> 15);
    bias_acc = sat32(48'(bias_sum_r) + 48'(raw_r) + 48'(lt_r));
    w_nxt    = sat24(48'(raw_r) - 48'(bias_sum_r) + 48'(lt_r));
    // g*s + (1-g)*w folded to w + g*(s - w): one multiplier
    diff     = 25'(s_r) - 25'(w_r);
    fprod    = $signed({1'b0, filter_gain}) * diff;
    facc     = (48'(w_r) <<< 16) + 48'(fprod) + 48'sd32768;
    s_nxt    = sat24(facc >>> 16);
    prod_nxt = row_r * s_r;
  end

  fcd_cdiv #(
    .DIVISOR (CALIB_SAMPLES)
  ) u_bias_div (
    .clk (clk),
    .num (33'(bias_sum_r)),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_sum_r <= '0;
      s_r        <= '0;
    end else begin
      if (ctrl.cal_acc) begin
        bias_sum_r <= bias_acc;
      end else if (ctrl.bias_load) begin
        // Replace the sum by the mean
        bias_sum_r <= quo[31:0];
      end
      if (ctrl.filt) begin
        s_r <= s_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      raw_r <= raw;
      row_r <= row;
    end
    if (ctrl.load_term) begin
      lt_r <= lt_nxt;
    end
    if (ctrl.comp) begin
      w_r <= w_nxt;
    end
    if (ctrl.proj) begin
      prod_r <= prod_nxt;
    end
  end

  assign filt = s_r;
  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== rtl/fcd_merge.sv =====
// Merging stage: sums the lane projections into the normal force and keeps
// the moving-average window. Uses fcd_pkg, fcd_ram and fcd_cdiv.
`timescale 1ns / 1ps
`default_nettype none

module fcd_merge
  import fcd_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire merge_ctrl_t        ctrl,
  input  wire logic signed [39:0] prod_x,
  input  wire logic signed [39:0] prod_y,
  input  wire logic signed [39:0] prod_z,
  output logic                    win_full,
  output logic signed      [23:0] normal_force,
  output logic signed      [23:0] force_average
);

  localparam int unsigned PTR_W = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W = 24 + PTR_W;
  localparam logic        [PTR_W-1:0] LAST = PTR_W'(WINDOW_LEN - 1);
  localparam logic        [CNT_W-1:0] FULL = CNT_W'(WINDOW_LEN);
  localparam logic signed [32:0]      HALF = 33'(WINDOW_LEN / 2);

  logic signed [23:0]      nf_r;
  logic signed [23:0]      nf_nxt;
  logic signed [47:0]      acc;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;
  logic        [CNT_W-1:0] fill_r;
  logic        [PTR_W-1:0] pos_r;
  logic        [PTR_W-1:0] pos_nxt;
  logic signed [23:0]      avg_r;
  logic        [23:0]      rd_data;
  logic signed [23:0]      oldest;
  logic signed [32:0]      num;
  logic signed [32:0]      quo;

  assign win_full = (fill_r == FULL);
  assign oldest   = $signed(rd_data);

  always_comb begin
    acc    = 48'(prod_x) + 48'(prod_y) + 48'(prod_z) + 48'sd16384;
    nf_nxt = sat24(acc >>> 15);
    if (win_full) begin
      sum_nxt = SUM_W'(34'(sum_r) + 34'(nf_r) - 34'(oldest));
    end else begin
      sum_nxt = SUM_W'(34'(sum_r) + 34'(nf_r));
    end
    pos_nxt = (pos_r == LAST) ? '0 : pos_r + PTR_W'(1);
    num     = 33'(sum_r) + HALF;
  end

  // Read the oldest entry during the sum cycle, overwrite it in the following window cycle
  fcd_ram #(
    .WIDTH (24),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk     (clk),
    .wr_en   (ctrl.win),
    .wr_addr (pos_r),
    .wr_data (nf_r),
    .rd_en   (ctrl.sum),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  fcd_cdiv #(
    .DIVISOR (WINDOW_LEN)
  ) u_avg_div (
    .clk (clk),
    .num (num),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
      pos_r  <= '0;
    end else if (ctrl.win) begin
      sum_r <= sum_nxt;
      pos_r <= pos_nxt;
      if (!win_full) begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      nf_r <= nf_nxt;
    end
    if (ctrl.win && !win_full) begin
      avg_r <= '0;
    end else if (ctrl.avg_load) begin
      // Mean of 24-bit values always fits 24 bits
      avg_r <= quo[23:0];
    end
  end

  assign normal_force  = nf_r;
  assign force_average = avg_r;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for force_contact_detector: a directed table, then random phases under
// varied register settings, every result checked against a behavioural predictor.
// Depends on fcd_pkg and the force_contact_detector RTL; needs nothing else.

module tb;
  import fcd_pkg::*;

  localparam int CAL_N       = 64;
  localparam int WIN_N       = 16;
  localparam int N_PHASE     = 8;
  localparam int PHASE_ITEMS = 170;
  localparam int LAT_TAIL    = 16;
  // worst quiet stretch: an input gap, the result latency, chained stalls, a drain and
  // eight register writes; taken many times over
  localparam int STUCK_LIMIT = 2000;

  localparam longint MAX24   = 64'sd8388607;
  localparam longint MIN24   = -64'sd8388608;
  localparam longint MAX32   = 64'sd2147483647;
  localparam longint MIN32   = -64'sd2147483648;
  localparam longint ONE_Q15 = 64'sd32767;
  localparam longint NEG_Q15 = -64'sd32768;
  localparam longint ALT_A24 = 64'sd5592405;
  localparam longint ALT_B24 = -64'sd5592406;
  localparam longint ALT_A16 = 64'sd21845;
  localparam longint ALT_B16 = -64'sd21846;

  localparam out_item_t CAL_RESULT = '0;

  typedef struct {
    in_item_t sample;
    bit       known;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // register shadows
  longint gain_r = longint'(FILTER_GAIN_RST);
  longint load_r = longint'(LOAD_WEIGHT_RST);
  longint fthr_r = longint'(FORCE_THRESHOLD_RST);
  longint dthr_r = longint'(DEPTH_THRESHOLD_RST);
  longint surf_r = longint'(SURFACE_HEIGHT_RST);

  // predictor state
  longint bias_acc[3] = '{0, 0, 0};
  bit     bias_set    = 1'b0;
  int     cal_seen    = 0;
  longint smooth[3]   = '{0, 0, 0};
  longint win_val[WIN_N];
  int     win_fill    = 0;
  int     win_pos     = 0;
  longint win_sum     = 0;

  // stimulus state
  longint    sensor_off[3];
  longint    press_level = 0;
  int        press_left  = 0;
  bit        calm        = 1'b0;
  bit        cur_known   = 1'b0;
  int        stall_left  = 0;
  int        n_sent      = 0;
  stim_row_t stim_rows[$];

  out_item_t pending_results[$];
  int n_fail     = 0;
  int n_checked  = 0;
  int n_contact  = 0;
  int n_near     = 0;
  int n_none     = 0;
  int n_settings = 0;
  int stuck      = 0;

  force_contact_detector #(
    .CALIB_SAMPLES(CAL_N),
    .WINDOW_LEN   (WIN_N)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint fdiv(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint spread(input int unsigned m);
    return longint'($urandom_range(0, 2 * m)) - longint'(m);
  endfunction

  function automatic out_item_t predict_contact(input in_item_t s);
    longint    raw[3];
    longint    row[3];
    longint    lt[3];
    longint    w, acc, nf, avg, height_gap;
    out_item_t r;
    r = '0;
    raw[0] = longint'($signed(s.force_x));
    raw[1] = longint'($signed(s.force_y));
    raw[2] = longint'($signed(s.force_z));
    row[0] = longint'($signed(s.rot_zx));
    row[1] = longint'($signed(s.rot_zy));
    row[2] = longint'($signed(s.rot_zz));
    for (int k = 0; k < 3; k++) begin
      lt[k] = fdiv(load_r * row[k] + 16384, 32768);
    end
    if (!bias_set) begin
      for (int k = 0; k < 3; k++) begin
        bias_acc[k] = clip(bias_acc[k] + raw[k] + lt[k], MIN32, MAX32);
      end
      cal_seen++;
      if (cal_seen < CAL_N) begin
        return r;
      end
      // last calibration sample: fix the bias and carry on with this sample
      for (int k = 0; k < 3; k++) begin
        bias_acc[k] = fdiv(bias_acc[k], CAL_N);
      end
      bias_set = 1'b1;
    end
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      w = clip(raw[k] - bias_acc[k] + lt[k], MIN24, MAX24);
      smooth[k] = clip(fdiv(gain_r * smooth[k] + (65536 - gain_r) * w + 32768, 65536),
                       MIN24, MAX24);
      acc += row[k] * smooth[k];
    end
    nf = clip(fdiv(acc + 16384, 32768), MIN24, MAX24);
    if (win_fill < WIN_N) begin
      win_sum += nf;
      win_fill++;
      avg = 0;
    end else begin
      win_sum += nf - win_val[win_pos];
      avg = fdiv(win_sum + WIN_N / 2, WIN_N);
    end
    win_val[win_pos] = nf;
    win_pos = (win_pos + 1) % WIN_N;
    avg = clip(avg, MIN24, MAX24);
    height_gap = longint'($signed(s.tool_height)) - surf_r;
    if (height_gap < dthr_r) begin
      r.contact_state = (avg >= fthr_r) ? CS_CONTACT : CS_NEAR;
    end else begin
      r.contact_state = CS_NONE;
    end
    r.bias_ready    = 1'b1;
    r.normal_force  = 24'(nf);
    r.force_average = 24'(avg);
    r.filtered_x    = 24'(smooth[0]);
    r.filtered_y    = 24'(smooth[1]);
    r.filtered_z    = 24'(smooth[2]);
    return r;
  endfunction

  // Mostly plausible poses with a held press level, so the window average climbs
  // past the threshold; the rest is full-range noise once the bias is fixed.
  function automatic in_item_t draw_sample();
    in_item_t s;
    longint   row[3];
    longint   raw[3];
    longint   a, b, lt, th;
    int       pick;
    if (bias_set && $urandom_range(0, 99) < 14) begin
      s.force_x     = 24'($urandom);
      s.force_y     = 24'($urandom);
      s.force_z     = 24'($urandom);
      s.rot_zx      = 16'($urandom);
      s.rot_zy      = 16'($urandom);
      s.rot_zz      = 16'($urandom);
      s.tool_height = 24'($urandom);
      return s;
    end
    pick = int'($urandom_range(0, 9));
    if (pick < 4) begin
      row[0] = 0; row[1] = 0; row[2] = ONE_Q15;
    end else if (pick < 5) begin
      row[0] = 0; row[1] = 0; row[2] = NEG_Q15;
    end else if (pick < 9) begin
      a = spread(12000);
      b = spread(12000);
      row[0] = a;
      row[1] = b;
      row[2] = longint'($sqrt(real'(ONE_Q15 * ONE_Q15 - a * a - b * b)));
    end else begin
      row[0] = longint'($signed(16'($urandom)));
      row[1] = longint'($signed(16'($urandom)));
      row[2] = longint'($signed(16'($urandom)));
    end
    if (!bias_set) begin
      press_level = 0;
    end else if (press_left == 0) begin
      case ($urandom_range(0, 3))
        0:       press_level = 0;
        1:       press_level = spread(3000);
        2:       press_level = longint'($urandom_range(2000, 60000));
        default: press_level = -longint'($urandom_range(2000, 60000));
      endcase
      press_left = int'($urandom_range(6, 40));
    end else begin
      press_left--;
    end
    for (int k = 0; k < 3; k++) begin
      lt = fdiv(load_r * row[k] + 16384, 32768);
      raw[k] = clip(sensor_off[k] - lt + fdiv(press_level * row[k], 32768) + spread(300),
                    MIN24, MAX24);
    end
    if ($urandom_range(0, 9) == 0) begin
      th = clip(surf_r + dthr_r - longint'($urandom_range(0, 1)), MIN24, MAX24);
    end else begin
      th = clip(surf_r + spread(40000), MIN24, MAX24);
    end
    s.force_x     = 24'(raw[0]);
    s.force_y     = 24'(raw[1]);
    s.force_z     = 24'(raw[2]);
    s.rot_zx      = 16'(row[0]);
    s.rot_zy      = 16'(row[1]);
    s.rot_zz      = 16'(row[2]);
    s.tool_height = 24'(th);
    return s;
  endfunction

  function automatic void add_row(input longint fx, fy, fz, rx, ry, rz, th,
                                  input bit known);
    stim_row_t r;
    r.sample.force_x     = 24'(fx);
    r.sample.force_y     = 24'(fy);
    r.sample.force_z     = 24'(fz);
    r.sample.rot_zx      = 16'(rx);
    r.sample.rot_zy      = 16'(ry);
    r.sample.rot_zz      = 16'(rz);
    r.sample.tool_height = 24'(clip(th, MIN24, MAX24));
    r.known              = known;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  task automatic send_sample(input in_item_t s, input bit known);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = int'($urandom_range(1, 14));
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= s;
    cur_known <= known;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input longint val);
    logic [23:0] v;
    v = val[23:0];
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      CFG_FILTER_GAIN:     gain_r = longint'(v[15:0]);
      CFG_LOAD_WEIGHT:     load_r = longint'(v[19:0]);
      CFG_FORCE_THRESHOLD: fthr_r = longint'(v[22:0]);
      CFG_DEPTH_THRESHOLD: dthr_r = longint'($signed(v));
      CFG_SURFACE_HEIGHT:  surf_r = longint'($signed(v));
      default: ;
    endcase
  endtask

  task automatic program_setting(input int ph);
    longint g, lw, ft, dt, sh;
    case (ph)
      0: begin
        g  = longint'(FILTER_GAIN_RST);
        lw = longint'(LOAD_WEIGHT_RST);
        ft = longint'(FORCE_THRESHOLD_RST);
        dt = longint'(DEPTH_THRESHOLD_RST);
        sh = longint'(SURFACE_HEIGHT_RST);
      end
      1: begin
        g = 0; lw = 0; ft = 0; dt = MAX24; sh = MIN24;
      end
      2: begin
        g = 65535; lw = 1048575; ft = 8388607; dt = MIN24; sh = MAX24;
      end
      N_PHASE: begin
        g = 32768; lw = 2000; ft = 6000; dt = 20000; sh = -5000;
      end
      default: begin
        g  = longint'($urandom_range(0, 65535));
        lw = longint'($urandom_range(0, 30000));
        ft = longint'($urandom_range(0, 40000));
        dt = spread(60000);
        sh = spread(200000);
      end
    endcase
    cfg_write(CFG_FILTER_GAIN, g);
    cfg_write(CFG_LOAD_WEIGHT, lw);
    cfg_write(CFG_FORCE_THRESHOLD, ft);
    cfg_write(CFG_DEPTH_THRESHOLD, dt);
    cfg_write(CFG_SURFACE_HEIGHT, sh);
    // unmapped indexes must leave every register alone
    for (int i = int'(CFG_SURFACE_HEIGHT) + 1; i < (1 << CFG_IDX_W); i++) begin
      cfg_write(CFG_IDX_W'(i), longint'($urandom));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = int'($urandom_range(0, 13));
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no sample waiting");
          n_fail++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("bias_ready", want.bias_ready, out_data.bias_ready);
          check_field("normal_force", $signed(want.normal_force),
                      $signed(out_data.normal_force));
          check_field("force_average", $signed(want.force_average),
                      $signed(out_data.force_average));
          check_field("contact_state", want.contact_state, out_data.contact_state);
          check_field("filtered_x", $signed(want.filtered_x), $signed(out_data.filtered_x));
          check_field("filtered_y", $signed(want.filtered_y), $signed(out_data.filtered_y));
          check_field("filtered_z", $signed(want.filtered_z), $signed(out_data.filtered_z));
          n_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        pred = predict_contact(in_data);
        pending_results.insert(pending_results.size(), cur_known ? CAL_RESULT : pred);
        if (pred.bias_ready) begin
          case (pred.contact_state)
            CS_CONTACT: n_contact++;
            CS_NEAR:    n_near++;
            default:    n_none++;
          endcase
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= STUCK_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < 3; k++) begin
      sensor_off[k] = spread(200000);
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    program_setting(0);

    // calibration samples: the result must be all zero
    add_row(0, 0, 0, 0, 0, 0, 0, 1'b1);
    add_row(MAX24, MAX24, MAX24, ONE_Q15, ONE_Q15, ONE_Q15, MAX24, 1'b1);
    add_row(MIN24, MIN24, MIN24, NEG_Q15, NEG_Q15, NEG_Q15, MIN24, 1'b1);
    add_row(MIN24, MAX24, MIN24, ONE_Q15, NEG_Q15, ONE_Q15, MAX24, 1'b1);
    add_row(MAX24, MIN24, MAX24, NEG_Q15, ONE_Q15, NEG_Q15, MIN24, 1'b1);
    add_row(-1, -1, -1, -1, -1, -1, -1, 1'b1);
    add_row(1, 1, 1, 1, 1, 1, 1, 1'b1);
    add_row(ALT_A24, ALT_B24, ALT_A24, ALT_A16, ALT_B16, ALT_A16, ALT_B24, 1'b1);
    add_row(ALT_B24, ALT_A24, ALT_B24, ALT_B16, ALT_A16, ALT_B16, ALT_A24, 1'b1);
    add_row(0, 0, 0, 0, 0, ONE_Q15, surf_r, 1'b1);
    // after calibration: saturation, non-unit rows, depth boundary
    add_row(0, 0, 0, 0, 0, ONE_Q15, surf_r - 100000, 1'b0);
    add_row(MAX24, MAX24, MAX24, ONE_Q15, ONE_Q15, ONE_Q15, 0, 1'b0);
    add_row(MIN24, MIN24, MIN24, NEG_Q15, NEG_Q15, NEG_Q15, 0, 1'b0);
    add_row(MAX24, MAX24, MAX24, 0, 0, 0, MIN24, 1'b0);
    add_row(MAX24, MAX24, MAX24, 0, 0, 0, MAX24, 1'b0);
    add_row(MIN24, MIN24, MIN24, 0, 0, ONE_Q15, surf_r + dthr_r, 1'b0);
    add_row(MIN24, MIN24, MIN24, 0, 0, ONE_Q15, surf_r + dthr_r - 1, 1'b0);
    add_row(MAX24, 0, 0, ONE_Q15, 0, 0, 0, 1'b0);
    add_row(0, MIN24, 0, 0, NEG_Q15, 0, 0, 1'b0);
    add_row(ALT_B24, ALT_B24, ALT_B24, ALT_A16, ALT_A16, ALT_A16, ALT_A24, 1'b0);
    add_row(0, 0, 0, 0, 0, 0, 0, 1'b0);

    foreach (stim_rows[i]) begin
      // pad the calibration with quiet samples before the first post-calibration row
      if (!stim_rows[i].known) begin
        while (n_sent < CAL_N) send_sample(draw_sample(), 1'b0);
      end
      send_sample(stim_rows[i].sample, stim_rows[i].known);
    end

    for (int ph = 1; ph <= N_PHASE; ph++) begin
      drain_results();
      program_setting(ph);
      calm = (ph == 4) || (ph == N_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 149) == 0) begin
          drain_results();
        end
        send_sample(draw_sample(), 1'b0);
      end
    end

    drain_results();
    repeat (LAT_TAIL) @(posedge clk);
    $display("ran %0d samples over %0d register settings, %0d results checked",
             n_sent, n_settings, n_checked);
    $display("after calibration: %0d contact, %0d near, %0d clear", n_contact, n_near,
             n_none);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fcd_pkg.sv
rtl/fcd_ram.sv
rtl/fcd_cdiv.sv
rtl/fcd_lane.sv
rtl/fcd_merge.sv
rtl/force_contact_detector.sv
verif/tb.sv
